// File: sv/plob_pkg.sv
// ----------------------------------------------------------------------------
// Price level order book package
// Shared widths, codes, the queue entry type and the result type.
// ----------------------------------------------------------------------------
`default_nettype none

package plob_pkg;

    localparam int LEVELS = 16;
    localparam int IDX_W  = $clog2(LEVELS);
    localparam int CNT_W  = $clog2(LEVELS + 1);

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [0:0] REG_VWAP_LEVELS = 1'b0;
    localparam logic [0:0] REG_IMB_LEVELS  = 1'b1;

    // Operations handed from the front end to the back end.
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_UPSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic        add;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
    } cmd_t;

    typedef struct packed {
        logic        bid_valid;
        logic        ask_valid;
        logic [31:0] top_bid;
        logic [31:0] top_ask;
        logic [32:0] spread;
        logic [32:0] mid_doubled;
        logic [15:0] imbalance;
        logic [39:0] vwap;
        logic        overflow;
    } res_t;

endpackage

`default_nettype wire

// File: sv/plob_front.sv
// ----------------------------------------------------------------------------
// Order book front end
// Accepts input words, classifies them and feeds a two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module plob_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    kind,
    input  wire logic          side,
    input  wire logic [31:0]   price,
    input  wire logic [31:0]   quantity,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output plob_pkg::cmd_t     cmd
);
    import plob_pkg::*;

    cmd_t       q_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    cmd_t       c;
    logic       push, pop;

    always_comb
    begin
        c.side  = side;
        c.price = price;
        c.qty   = quantity;
        c.add   = (kind == KIND_ADD);
        unique case (kind)
            KIND_CLEAR:  c.op = OP_CLEAR;
            KIND_REMOVE: c.op = OP_REMOVE;
            KIND_SET:    c.op = (quantity == 32'd0) ? OP_REMOVE : OP_UPSERT;
            default:     c.op = (price != 32'd0 && quantity != 32'd0) ? OP_UPSERT : OP_NONE;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

// File: sv/plob_div.sv
// ----------------------------------------------------------------------------
// Order book divider
// Restoring divider, one quotient bit per cycle, shared by both statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module plob_div
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [6:0]    nbits,
    input  wire logic [127:0]  dividend,
    input  wire logic [40:0]   divisor,
    output logic               busy,
    output logic [39:0]        quotient
);
    logic [127:0] num_reg;
    logic [41:0]  rem_reg;
    logic [40:0]  den_reg;
    logic [39:0]  quo_reg;
    logic [6:0]   left_reg;
    logic [41:0]  trial;
    logic         ge;

    assign trial    = {rem_reg[40:0], num_reg[127]};
    assign ge       = (trial >= {1'b0, den_reg});
    assign busy     = (left_reg != 7'd0);
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy)
        begin
            num_reg <= {num_reg[126:0], 1'b0};
            rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[38:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 7'd0;
        end
        else if (start)
        begin
            left_reg <= nbits;
        end
        else if (busy)
        begin
            left_reg <= left_reg - 7'd1;
        end
    end

endmodule

`default_nettype wire

// File: sv/plob_back.sv
// ----------------------------------------------------------------------------
// Order book back end
// Updates the sorted level tables and computes the top-of-book statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module plob_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire plob_pkg::cmd_t cmd,
    input  wire logic [4:0]    vwap_levels,
    input  wire logic [4:0]    imb_levels,
    output logic               res_valid,
    input  wire logic          res_ready,
    output plob_pkg::res_t     res
);
    import plob_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_APPLY = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_IMB   = 4'd5;
    localparam logic [3:0] S_DIV1  = 4'd6;
    localparam logic [3:0] S_VW    = 4'd7;
    localparam logic [3:0] S_DIV2  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]       state_reg;
    logic [31:0]      pr_reg  [2][LEVELS];
    logic [31:0]      qt_reg  [2][LEVELS];
    logic [CNT_W-1:0] cnt_reg [2];
    cmd_t             cmd_reg;
    logic             ovf_reg;

    // Statistics walk: one level of one side at a time, through S_SUM and S_MUL.
    logic             sd_reg;
    logic [IDX_W-1:0] ix_reg;
    logic [35:0]      bq_reg, aq_reg;
    logic [36:0]      qs_reg;
    logic [68:0]      pv_reg;
    logic [63:0]      prod_reg;
    logic [31:0]      mq_reg;
    logic             in_vw_reg, in_imb_reg;
    logic [15:0]      imb_reg;
    logic             neg_reg;
    logic [50:0]      mag_reg;
    res_t             res_reg;
    logic             res_valid_reg;
    logic [36:0]      tot;
    logic             res_load;

    logic             div_start, div_busy;
    logic [6:0]       div_nbits;
    logic [127:0]     div_num;
    logic [40:0]      div_den;
    logic [39:0]      div_q;

    plob_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .nbits    (div_nbits),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Combinational view of the active side for the apply step.
    logic [LEVELS-1:0] hit, better;
    logic [IDX_W-1:0]  hit_ix;
    logic [CNT_W-1:0]  pos, n_cur;
    logic              found;
    logic [32:0]       qsum;
    logic              ovf_next;

    always_comb
    begin
        n_cur  = cnt_reg[cmd_reg.side];
        hit_ix = '0;
        found  = 1'b0;
        pos    = n_cur;
        for (int i = 0; i < LEVELS; i++)
        begin
            hit[i]    = (CNT_W'(i) < n_cur) && (pr_reg[cmd_reg.side][i] == cmd_reg.price);
            better[i] = (CNT_W'(i) < n_cur) && (cmd_reg.side
                        ? (cmd_reg.price < pr_reg[1][i]) : (cmd_reg.price > pr_reg[0][i]));
        end
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_ix = IDX_W'(i);
                found  = 1'b1;
            end
            if (better[i])
            begin
                pos = CNT_W'(i);
            end
        end
        qsum     = {1'b0, qt_reg[cmd_reg.side][hit_ix]} + {1'b0, cmd_reg.qty};
        ovf_next = (cmd_reg.op == OP_UPSERT)
                   && (found ? (cmd_reg.add && qsum[32]) : (n_cur == CNT_W'(LEVELS)));
    end

    logic [CNT_W-1:0] nlev;
    assign nlev = cnt_reg[sd_reg];

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign tot       = {1'b0, bq_reg} + {1'b0, aq_reg};
    assign res_load  = (state_reg == S_OUT) && (!res_valid_reg || res_ready);

    always_comb
    begin
        div_start = 1'b0;
        div_nbits = 7'd51;
        div_num   = {mag_reg, 77'd0};
        div_den   = {4'd0, tot};
        if (state_reg == S_IMB && tot != 37'd0)
        begin
            div_start = 1'b1;
        end
        if (state_reg == S_VW)
        begin
            div_nbits = 7'd77;
            div_num   = {pv_reg, 8'd0, 51'd0};
            div_den   = {4'd0, qs_reg};
            div_start = (qs_reg != 37'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_reg <= cmd;
                end
            end
            S_APPLY:
            begin
                ovf_reg <= ovf_next;
                if (cmd_reg.op == OP_REMOVE && found)
                begin
                    for (int i = 0; i < LEVELS - 1; i++)
                    begin
                        if (IDX_W'(i) >= hit_ix)
                        begin
                            pr_reg[cmd_reg.side][i] <= pr_reg[cmd_reg.side][i + 1];
                            qt_reg[cmd_reg.side][i] <= qt_reg[cmd_reg.side][i + 1];
                        end
                    end
                end
                else if (cmd_reg.op == OP_UPSERT && found)
                begin
                    if (!cmd_reg.add)
                    begin
                        qt_reg[cmd_reg.side][hit_ix] <= cmd_reg.qty;
                    end
                    else if (qsum[32])
                    begin
                        qt_reg[cmd_reg.side][hit_ix] <= '1;
                    end
                    else
                    begin
                        qt_reg[cmd_reg.side][hit_ix] <= qsum[31:0];
                    end
                end
                else if (cmd_reg.op == OP_UPSERT)
                begin
                    if (pos < CNT_W'(LEVELS))
                    begin
                        for (int i = 1; i < LEVELS; i++)
                        begin
                            if (CNT_W'(i) > pos)
                            begin
                                pr_reg[cmd_reg.side][i] <= pr_reg[cmd_reg.side][i - 1];
                                qt_reg[cmd_reg.side][i] <= qt_reg[cmd_reg.side][i - 1];
                            end
                        end
                        pr_reg[cmd_reg.side][pos[IDX_W-1:0]] <= cmd_reg.price;
                        qt_reg[cmd_reg.side][pos[IDX_W-1:0]] <= cmd_reg.qty;
                    end
                end
                sd_reg <= 1'b0;
                ix_reg <= '0;
                bq_reg <= '0;
                aq_reg <= '0;
                qs_reg <= '0;
                pv_reg <= '0;
            end
            S_SUM:
            begin
                in_vw_reg  <= ({1'b0, ix_reg} < nlev) && ({1'b0, ix_reg} < vwap_levels);
                in_imb_reg <= ({1'b0, ix_reg} < nlev) && ({1'b0, ix_reg} < imb_levels);
                mq_reg     <= qt_reg[sd_reg][ix_reg];
                prod_reg   <= pr_reg[sd_reg][ix_reg] * qt_reg[sd_reg][ix_reg];
            end
            S_MUL:
            begin
                if (in_vw_reg)
                begin
                    pv_reg <= pv_reg + {5'd0, prod_reg};
                    qs_reg <= qs_reg + {5'd0, mq_reg};
                end
                if (in_imb_reg)
                begin
                    if (sd_reg)
                    begin
                        aq_reg <= aq_reg + {4'd0, mq_reg};
                    end
                    else
                    begin
                        bq_reg <= bq_reg + {4'd0, mq_reg};
                    end
                end
                if (ix_reg == IDX_W'(LEVELS - 1))
                begin
                    sd_reg <= ~sd_reg;
                end
                ix_reg <= ix_reg + 1'b1;
            end
            S_ACC:
            begin
                neg_reg <= (aq_reg > bq_reg);
                mag_reg <= 51'((aq_reg > bq_reg) ? (aq_reg - bq_reg) : (bq_reg - aq_reg))
                           * 51'd32767;
                imb_reg <= '0;
            end
            S_DIV1:
            begin
                if (!div_busy && tot != 37'd0)
                begin
                    imb_reg <= neg_reg ? (16'd0 - div_q[15:0]) : div_q[15:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    logic [32:0] bb, ba;
    logic        bv, av;

    always_comb
    begin
        bv = (cnt_reg[0] != '0);
        av = (cnt_reg[1] != '0);
        bb = bv ? {1'b0, pr_reg[0][0]} : 33'd0;
        ba = av ? {1'b0, pr_reg[1][0]} : 33'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (cmd_reg.op == OP_CLEAR)
                    begin
                        cnt_reg[0] <= '0;
                        cnt_reg[1] <= '0;
                    end
                    else if (cmd_reg.op == OP_REMOVE && found)
                    begin
                        cnt_reg[cmd_reg.side] <= n_cur - 1'b1;
                    end
                    else if (cmd_reg.op == OP_UPSERT && !found
                             && n_cur != CNT_W'(LEVELS))
                    begin
                        cnt_reg[cmd_reg.side] <= n_cur + 1'b1;
                    end
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= (sd_reg && ix_reg == IDX_W'(LEVELS - 1)) ? S_ACC : S_SUM;
                end
                S_ACC:
                begin
                    state_reg <= S_IMB;
                end
                S_IMB:
                begin
                    state_reg <= S_DIV1;
                end
                S_DIV1:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_VW;
                    end
                end
                S_VW:
                begin
                    state_reg <= S_DIV2;
                end
                S_DIV2:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (res_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg.bid_valid   <= bv;
            res_reg.ask_valid   <= av;
            res_reg.top_bid     <= bb[31:0];
            res_reg.top_ask     <= ba[31:0];
            res_reg.spread      <= (bv && av) ? (ba - bb) : 33'd0;
            res_reg.mid_doubled <= (bv && av) ? (ba + bb) : 33'd0;
            res_reg.imbalance   <= imb_reg;
            res_reg.vwap        <= (qs_reg != 37'd0) ? div_q : 40'd0;
            res_reg.overflow    <= ovf_reg;
        end
    end

endmodule

`default_nettype wire

// File: sv/price_level_order_book_top.sv
// ----------------------------------------------------------------------------
// Price level order book
// Sorted bid and ask level tables with top-of-book statistics per word.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  s_axis   in         order word: kind, side, price, quantity
//  m_axis   out        statistics word, one per input word
//  cfg      in         vwap_levels (0), imbalance_levels (1)
//
//  An item walks both tables one level at a time, with a product step and an
//  accumulate step per level through one multiplier; the shared bit-serial
//  divider then runs for the imbalance and for the VWAP, each division being
//  skipped when its sum is zero. A two-word queue parts the input from the
//  back end, and the result register frees the back end for the next word.
//  Reset is asynchronous and leaves both sides empty with both registers at 5.
// ----------------------------------------------------------------------------
`default_nettype none

module price_level_order_book_top
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // side, price, quantity from bit 0; padded to 72 bits
    input  wire logic [71:0]   s_axis_tdata,
    // kind
    input  wire logic [1:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // bid_valid, ask_valid, top bid, top ask, spread, mid_doubled,
    // imbalance, vwap, overflow from bit 0; padded to 192 bits
    output logic [191:0]       m_axis_tdata,
    input  wire logic          cfg_we,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [4:0]    cfg_data
);
    import plob_pkg::*;

    logic [4:0] vwap_lv_reg, imb_lv_reg;
    logic       cmd_valid, cmd_ready;
    cmd_t       cmd;
    res_t       res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vwap_lv_reg <= 5'd5;
            imb_lv_reg  <= 5'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VWAP_LEVELS: vwap_lv_reg <= cfg_data;
                REG_IMB_LEVELS:  imb_lv_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    plob_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .kind      (s_axis_tuser),
        .side      (s_axis_tdata[0]),
        .price     (s_axis_tdata[32:1]),
        .quantity  (s_axis_tdata[64:33]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    plob_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .vwap_levels (vwap_lv_reg),
        .imb_levels  (imb_lv_reg),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    assign m_axis_tdata = {3'd0, res.overflow, res.vwap, res.imbalance, res.mid_doubled,
                           res.spread, res.top_ask, res.top_bid, res.ask_valid,
                           res.bid_valid};

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Price level order book testbench
// Drives order words through the stream input, predicts every statistics word
// from its own model of the two level tables or a typed expectation, and checks
// each output word field by field under random idling on both sides and
// several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import plob_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 2500;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [1:0]  kind;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
        logic        typed;
        res_t        want;
    } order_t;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [71:0]   s_axis_tdata;
    logic [1:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [191:0]  m_axis_tdata;
    logic          cfg_we;
    logic [0:0]    cfg_index;
    logic [4:0]    cfg_data;

    // Model of the level tables, index 0 is the bid side.
    logic [31:0] lvl_px  [2][LEVELS];
    logic [31:0] lvl_qty [2][LEVELS];
    int          lvl_cnt [2];
    int          vwap_lv;
    int          imb_lv;

    order_t order_q[$];
    res_t   stats_q[$];
    logic   sending;
    logic   hold_req;
    int     errors;
    int     words_in;
    int     words_out;
    int     overflow_seen;
    int     cycles;

    price_level_order_book_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic is_better(input logic s, input logic [31:0] a, input logic [31:0] b);
        return s ? (a < b) : (a > b);
    endfunction

    function automatic int level_find(input logic s, input logic [31:0] pr);
        for (int i = 0; i < lvl_cnt[s]; i++)
        begin
            if (lvl_px[s][i] == pr)
                return i;
        end
        return -1;
    endfunction

    task automatic level_insert(input logic s, input logic [31:0] pr, input logic [31:0] qt,
                                output logic ovf);
        int n;
        int pos;
        n = lvl_cnt[s];
        pos = 0;
        ovf = 1'b0;
        while (pos < n && !is_better(s, pr, lvl_px[s][pos]))
            pos++;
        if (n >= LEVELS)
        begin
            ovf = 1'b1;
            if (pos >= LEVELS)
                return;
            n = LEVELS - 1;
        end
        for (int i = n; i > pos; i--)
        begin
            lvl_px[s][i]  = lvl_px[s][i-1];
            lvl_qty[s][i] = lvl_qty[s][i-1];
        end
        lvl_px[s][pos]  = pr;
        lvl_qty[s][pos] = qt;
        lvl_cnt[s] = n + 1;
    endtask

    task automatic level_remove(input logic s, input logic [31:0] pr);
        int idx;
        idx = level_find(s, pr);
        if (idx < 0)
            return;
        for (int i = idx; i + 1 < lvl_cnt[s]; i++)
        begin
            lvl_px[s][i]  = lvl_px[s][i+1];
            lvl_qty[s][i] = lvl_qty[s][i+1];
        end
        lvl_cnt[s]--;
    endtask

    // Applies one order word to the tables and computes the statistics word.
    task automatic book_update(input order_t o, output res_t r);
        int           idx;
        logic         ovf;
        logic [32:0]  qsum;
        logic [63:0]  bq;
        logic [63:0]  aq;
        logic [63:0]  tot;
        logic [63:0]  mag;
        logic [63:0]  qs;
        logic [127:0] pv;
        logic [127:0] quo;
        ovf = 1'b0;
        if (o.kind == KIND_CLEAR)
        begin
            lvl_cnt[0] = 0;
            lvl_cnt[1] = 0;
        end
        else if (o.kind == KIND_REMOVE || (o.kind == KIND_SET && o.qty == 0))
            level_remove(o.side, o.price);
        else if (o.kind == KIND_SET)
        begin
            idx = level_find(o.side, o.price);
            if (idx >= 0)
                lvl_qty[o.side][idx] = o.qty;
            else
                level_insert(o.side, o.price, o.qty, ovf);
        end
        else if (o.price != 0 && o.qty != 0)
        begin
            idx = level_find(o.side, o.price);
            if (idx >= 0)
            begin
                qsum = {1'b0, lvl_qty[o.side][idx]} + {1'b0, o.qty};
                if (qsum[32])
                begin
                    qsum = 33'hFFFFFFFF;
                    ovf = 1'b1;
                end
                lvl_qty[o.side][idx] = qsum[31:0];
            end
            else
                level_insert(o.side, o.price, o.qty, ovf);
        end

        r = '0;
        r.bid_valid = (lvl_cnt[0] != 0);
        r.ask_valid = (lvl_cnt[1] != 0);
        r.top_bid   = r.bid_valid ? lvl_px[0][0] : 32'd0;
        r.top_ask   = r.ask_valid ? lvl_px[1][0] : 32'd0;
        if (r.bid_valid && r.ask_valid)
        begin
            r.spread      = {1'b0, r.top_ask} - {1'b0, r.top_bid};
            r.mid_doubled = {1'b0, r.top_ask} + {1'b0, r.top_bid};
        end

        bq = 0;
        aq = 0;
        for (int i = 0; i < lvl_cnt[0] && i < imb_lv; i++)
            bq += 64'(lvl_qty[0][i]);
        for (int i = 0; i < lvl_cnt[1] && i < imb_lv; i++)
            aq += 64'(lvl_qty[1][i]);
        tot = bq + aq;
        if (tot != 0)
        begin
            mag = ((bq >= aq) ? bq - aq : aq - bq) * 64'd32767 / tot;
            r.imbalance = (bq >= aq) ? mag[15:0] : 16'(-mag[15:0]);
        end

        pv = 0;
        qs = 0;
        for (int sd = 0; sd < 2; sd++)
        begin
            for (int i = 0; i < lvl_cnt[sd] && i < vwap_lv; i++)
            begin
                pv += 128'(64'(lvl_px[sd][i]) * 64'(lvl_qty[sd][i]));
                qs += 64'(lvl_qty[sd][i]);
            end
        end
        if (qs != 0)
        begin
            quo = (pv << 8) / 128'(qs);
            r.vwap = quo[39:0];
        end
        r.overflow = ovf;
    endtask

    function automatic order_t make_order(input logic [1:0] k, input logic s,
                                          input logic [31:0] pr, input logic [31:0] qt);
        order_t o;
        o.kind = k;
        o.side = s;
        o.price = pr;
        o.qty = qt;
        o.typed = 1'b0;
        o.want = '0;
        return o;
    endfunction

    // Mostly clustered prices so that the tables fill and levels get hit again.
    function automatic order_t random_order(input logic [31:0] base);
        logic [1:0]  k;
        logic [31:0] pr;
        logic [31:0] qt;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 52)
            k = KIND_ADD;
        else if (r < 74)
            k = KIND_SET;
        else if (r < 97)
            k = KIND_REMOVE;
        else
            k = KIND_CLEAR;
        r = $urandom_range(0, 99);
        if (r < 80)
            pr = base + $urandom_range(0, 40);
        else if (r < 95)
            pr = $urandom;
        else
            pr = (r < 98) ? 32'd0 : 32'hFFFFFFFF;
        r = $urandom_range(0, 99);
        if (r < 70)
            qt = $urandom_range(1, 1000);
        else if (r < 80)
            qt = 32'd0;
        else if (r < 92)
            qt = $urandom;
        else
            qt = 32'hFFFFFFFF - $urandom_range(0, 3);
        return make_order(k, 1'($urandom_range(0, 1)), pr, qt);
    endfunction

    task automatic reg_write(input logic [0:0] idx, input logic [4:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_VWAP_LEVELS)
            vwap_lv = int'(val);
        else
            imb_lv = int'(val);
    endtask

    task automatic wait_idle();
        while (order_q.size() != 0 || sending || stats_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
        end
    endtask

    // Sender: one order word at a time with a random gap before each.
    initial
    begin
        order_t o;
        res_t   r;
        int     gap;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        sending = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            while (order_q.size() == 0)
            begin
                s_axis_tvalid = 1'b0;
                @(negedge clk);
            end
            sending = 1'b1;
            o = order_q.pop_front();
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_axis_tvalid = 1'b1;
            s_axis_tdata = {7'd0, o.qty, o.price, o.side};
            s_axis_tuser = o.kind;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            book_update(o, r);
            if (o.typed)
                r = o.want;
            stats_q = {stats_q, r};
            words_in++;
            if (order_q.size() == 0)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                sending = 1'b0;
            end
        end
    end

    // Receiver: random stalls, and one long hold-off on request.
    initial
    begin
        res_t got;
        res_t want;
        int   gap;
        logic held;
        m_axis_tready = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got.bid_valid   = m_axis_tdata[0];
            got.ask_valid   = m_axis_tdata[1];
            got.top_bid     = m_axis_tdata[33:2];
            got.top_ask     = m_axis_tdata[65:34];
            got.spread      = m_axis_tdata[98:66];
            got.mid_doubled = m_axis_tdata[131:99];
            got.imbalance   = m_axis_tdata[147:132];
            got.vwap        = m_axis_tdata[187:148];
            got.overflow    = m_axis_tdata[188];
            words_out++;
            if (stats_q.size() == 0)
            begin
                errors++;
                $display("%0t: output word with nothing expected, actual %0h",
                         $realtime, got);
            end
            else
            begin
                want = stats_q.pop_front();
                overflow_seen += want.overflow;
                check_field("bid_valid", want.bid_valid, got.bid_valid);
                check_field("ask_valid", want.ask_valid, got.ask_valid);
                check_field("top_bid", want.top_bid, got.top_bid);
                check_field("top_ask", want.top_ask, got.top_ask);
                check_field("spread", want.spread, got.spread);
                check_field("mid_doubled", want.mid_doubled, got.mid_doubled);
                check_field("imbalance", want.imbalance, got.imbalance);
                check_field("vwap", want.vwap, got.vwap);
                check_field("overflow", want.overflow, got.overflow);
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t: timeout with %0d words outstanding", $realtime, stats_q.size());
                $display("price_level_order_book_top test failed");
                $finish;
            end
        end
    end

    initial
    begin
        order_t      tbl[$];
        order_t      o;
        res_t        z;
        logic [31:0] base;
        int          phase_vwap[6];
        int          phase_imb[6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        errors = 0;
        words_in = 0;
        words_out = 0;
        overflow_seen = 0;
        lvl_cnt[0] = 0;
        lvl_cnt[1] = 0;
        vwap_lv = 5;
        imb_lv = 5;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows; typed expectations where the answer is plain.
        z = '0;
        o = make_order(KIND_REMOVE, 1'b0, 32'd5, 32'd9);
        o.typed = 1'b1; o.want = z; tbl = {tbl, o};
        o = make_order(KIND_ADD, 1'b0, 32'd0, 32'd7);
        o.typed = 1'b1; o.want = z; tbl = {tbl, o};
        o = make_order(KIND_ADD, 1'b1, 32'hFFFFFFFF, 32'd0);
        o.typed = 1'b1; o.want = z; tbl = {tbl, o};
        o = make_order(KIND_ADD, 1'b0, 32'd100, 32'd10);
        o.typed = 1'b1; o.want = z;
        o.want.bid_valid = 1'b1; o.want.top_bid = 32'd100;
        o.want.imbalance = 16'd32767; o.want.vwap = 40'd25600;
        tbl = {tbl, o};
        tbl = {tbl, make_order(KIND_ADD, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF)};
        tbl = {tbl, make_order(KIND_ADD, 1'b1, 32'hFFFFFFFF, 32'd1)};
        tbl = {tbl, make_order(KIND_SET, 1'b0, 32'd0, 32'd5)};
        tbl = {tbl, make_order(KIND_SET, 1'b0, 32'd100, 32'd0)};
        tbl = {tbl, make_order(KIND_REMOVE, 1'b1, 32'd12345, 32'd1)};
        tbl = {tbl, make_order(KIND_SET, 1'b1, 32'd200, 32'd3)};
        tbl = {tbl, make_order(KIND_ADD, 1'b0, 32'd300, 32'd4)};
        tbl = {tbl, make_order(KIND_SET, 1'b1, 32'd200, 32'hFFFFFFFF)};
        o = make_order(KIND_CLEAR, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        o.typed = 1'b1; o.want = z; tbl = {tbl, o};
        // Fill the bid side past its depth, then a worse level that is dropped.
        for (int i = 1; i <= LEVELS + 1; i++)
            tbl = {tbl, make_order(KIND_ADD, 1'b0, 32'(i * 10), 32'(i))};
        tbl = {tbl, make_order(KIND_ADD, 1'b0, 32'd1, 32'd1)};
        order_q = {order_q, tbl};
        wait_idle();

        phase_vwap = '{5, 1, 16, 0, 31, 3};
        phase_imb  = '{5, 16, 1, 31, 0, 8};
        for (int ph = 0; ph < 6; ph++)
        begin
            reg_write(REG_VWAP_LEVELS, 5'(phase_vwap[ph]));
            reg_write(REG_IMB_LEVELS, 5'(phase_imb[ph]));
            base = (ph % 2) ? 32'hFFFFFFD0 : 32'(1 + $urandom_range(0, 2000));
            if (ph == 1)
                hold_req = 1'b1;
            for (int i = 0; i < 320; i++)
                order_q = {order_q, random_order(base)};
            wait_idle();
        end

        $display("Checked %0d of %0d order words, %0d with overflow,", words_out, words_in,
                 overflow_seen);
        $display("over six register settings including zero and full depth.");
        if (errors == 0 && stats_q.size() == 0)
            $display("price_level_order_book_top test passed");
        else
            $display("price_level_order_book_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
